@@ src/kssl_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kssl_pkg - shared definitions for the keyed surface slot table
// Request and result layouts, slot record, operation codes and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package kssl_pkg;

  localparam int SLOTS = 16;
  localparam int IDXW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNTW  = $clog2(SLOTS + 1);

  // operation kinds
  localparam logic [2:0] KIND_ALLOC = 3'd0;
  localparam logic [2:0] KIND_FREE  = 3'd1;
  localparam logic [2:0] KIND_FIND  = 3'd2;
  localparam logic [2:0] KIND_READ  = 3'd3;
  localparam logic [2:0] KIND_SETB  = 3'd4;
  localparam logic [2:0] KIND_SETV  = 3'd5;

  // slot index source for the execute step
  localparam logic [1:0] SEL_HIT  = 2'd0;
  localparam logic [1:0] SEL_FREE = 2'd1;
  localparam logic [1:0] SEL_PICK = 2'd2;

  typedef struct packed {
    logic        [2:0]  kind;
    logic        [31:0] surface_key;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] size_w;
    logic signed [15:0] size_h;
    logic        [15:0] depth_rank;
    logic        [31:0] handle_tag;
    logic        [3:0]  slot_pick;
    logic               show;
  } item_t;

  typedef struct packed {
    logic               ok;
    logic        [3:0]  slot_hit;
    logic        [4:0]  live_total;
    logic               rec_active;
    logic        [31:0] rec_key;
    logic signed [15:0] rec_x;
    logic signed [15:0] rec_y;
    logic signed [15:0] rec_w;
    logic signed [15:0] rec_h;
    logic        [15:0] rec_depth;
    logic        [1:0]  rec_status;
    logic        [31:0] rec_handle;
  } result_t;

  typedef struct packed {
    logic               live;
    logic        [31:0] key;
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic signed [15:0] width;
    logic signed [15:0] height;
    logic        [15:0] depth;
    logic               shown;
    logic               dirty;
    logic        [31:0] handle;
  } slot_rec_t;

  typedef struct packed {
    logic       load;
    logic       match;
    logic       exec;
    logic       wr;
    logic       claim;
    logic       ok;
    logic       rec_en;
    logic [1:0] sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       hit;
    logic       room;
    logic       pick_ok;
  } dp_status_t;

endpackage
`default_nettype wire

@@ src/kssl_dpath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kssl_dpath - slot storage, key match and record update
// Holds the request, the slot records and the live count; matches the key
// against all slots, reads one record and writes changes back to it.
// ----------------------------------------------------------------------------
module kssl_dpath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire kssl_pkg::item_t     item,
  input  wire kssl_pkg::ctrl_cmd_t cmd,
  output kssl_pkg::dp_status_t     status,
  output logic                     done,
  output kssl_pkg::result_t        result
);

  localparam int PW = kssl_pkg::IDXW + 4;
  localparam int CW = kssl_pkg::CNTW + 5;

  kssl_pkg::item_t     req;
  kssl_pkg::slot_rec_t slots [kssl_pkg::SLOTS];
  logic [kssl_pkg::CNTW-1:0] live_count;
  logic [kssl_pkg::CNTW-1:0] live_count_next;

  logic                      hit;
  logic [kssl_pkg::IDXW-1:0] hit_idx;
  logic                      room;
  logic [kssl_pkg::IDXW-1:0] free_idx;

  logic                      hit_c;
  logic [kssl_pkg::IDXW-1:0] hit_idx_c;
  logic                      room_c;
  logic [kssl_pkg::IDXW-1:0] free_idx_c;
  logic [kssl_pkg::SLOTS-1:0] live_vec;

  logic [PW-1:0]             pick_wide;
  logic [kssl_pkg::IDXW-1:0] idx;
  kssl_pkg::slot_rec_t       old_rec;
  kssl_pkg::slot_rec_t       new_rec;
  logic [PW-1:0]             idx_wide;
  logic [CW-1:0]             cnt_wide;
  kssl_pkg::result_t         result_next;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= item;
    end
  end

  // parallel key compare, lowest match and lowest free slot
  always_comb begin
    hit_c      = 1'b0;
    hit_idx_c  = '0;
    room_c     = 1'b0;
    free_idx_c = '0;
    for (int i = kssl_pkg::SLOTS - 1; i >= 0; i--) begin
      live_vec[i] = slots[i].live;
      if (slots[i].live && (slots[i].key == req.surface_key)) begin
        hit_c     = 1'b1;
        hit_idx_c = kssl_pkg::IDXW'(i);
      end
      if (!slots[i].live) begin
        room_c     = 1'b1;
        free_idx_c = kssl_pkg::IDXW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.match) begin
      hit      <= hit_c;
      hit_idx  <= hit_idx_c;
      room     <= room_c;
      free_idx <= free_idx_c;
    end
  end

  assign pick_wide = {{kssl_pkg::IDXW{1'b0}}, req.slot_pick};

  assign status.kind    = req.kind;
  assign status.hit     = hit;
  assign status.room    = room;
  assign status.pick_ok = (pick_wide < PW'(kssl_pkg::SLOTS));

  always_comb begin
    case (cmd.sel)
      kssl_pkg::SEL_HIT:  idx = hit_idx;
      kssl_pkg::SEL_FREE: idx = free_idx;
      kssl_pkg::SEL_PICK: idx = pick_wide[kssl_pkg::IDXW-1:0];
      default:            idx = hit_idx;
    endcase
  end

  assign old_rec = slots[idx];

  always_comb begin
    new_rec = old_rec;
    case (req.kind)
      kssl_pkg::KIND_ALLOC: begin
        if (cmd.claim) begin
          new_rec.live  = 1'b1;
          new_rec.key   = req.surface_key;
          new_rec.shown = 1'b1;
          new_rec.dirty = 1'b1;
        end
        new_rec.left   = req.pos_x;
        new_rec.top    = req.pos_y;
        new_rec.width  = req.size_w;
        new_rec.height = req.size_h;
        new_rec.depth  = req.depth_rank;
        new_rec.handle = req.handle_tag;
      end
      kssl_pkg::KIND_FREE: begin
        new_rec.live   = 1'b0;
        new_rec.key    = '0;
        new_rec.handle = '0;
      end
      kssl_pkg::KIND_SETB: begin
        new_rec.left   = req.pos_x;
        new_rec.top    = req.pos_y;
        new_rec.width  = req.size_w;
        new_rec.height = req.size_h;
        new_rec.dirty  = 1'b1;
      end
      kssl_pkg::KIND_SETV: begin
        new_rec.shown = req.show;
        new_rec.dirty = 1'b1;
      end
      default: begin
        new_rec = old_rec;
      end
    endcase
  end

  always_comb begin
    live_count_next = live_count;
    if (cmd.exec && cmd.wr) begin
      if (cmd.claim) begin
        live_count_next = live_count + 1'b1;
      end else if ((req.kind == kssl_pkg::KIND_FREE) && (live_count != '0)) begin
        live_count_next = live_count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < kssl_pkg::SLOTS; i++) begin
        slots[i] <= '0;
      end
      live_count <= '0;
    end else begin
      if (cmd.exec && cmd.wr) begin
        slots[idx] <= new_rec;
      end
      live_count <= live_count_next;
    end
  end

  assign idx_wide = {4'b0, idx};
  assign cnt_wide = {5'b0, live_count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.exec;
    end
  end

  always_comb begin
    result_next            = '0;
    result_next.ok         = cmd.ok;
    result_next.live_total = cnt_wide[4:0];
    if (cmd.rec_en) begin
      result_next.slot_hit   = idx_wide[3:0];
      result_next.rec_active = new_rec.live;
      result_next.rec_key    = new_rec.key;
      result_next.rec_x      = new_rec.left;
      result_next.rec_y      = new_rec.top;
      result_next.rec_w      = new_rec.width;
      result_next.rec_h      = new_rec.height;
      result_next.rec_depth  = new_rec.depth;
      result_next.rec_status = {new_rec.dirty, new_rec.shown};
      result_next.rec_handle = new_rec.handle;
    end else if (cmd.sel == kssl_pkg::SEL_PICK) begin
      // out-of-range read still reports the requested slot number
      result_next.slot_hit = req.slot_pick;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      result <= result_next;
    end
  end

  // live count tracks the number of active slots
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(live_vec) == int'(live_count))
    else $error("live count disagrees with active slots");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(live_count) <= kssl_pkg::SLOTS)
    else $error("live count above table size");

  a_claim_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && cmd.claim |-> room && !hit)
    else $error("claim without a free slot or with a present key");

  a_fail_no_record: assert property (@(posedge clk) disable iff (rst)
    done && !result.ok |-> (result.rec_key == '0) && (result.rec_handle == '0)
                           && !result.rec_active)
    else $error("failed request carries a record");

endmodule
`default_nettype wire

@@ src/kssl_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kssl_ctrl - sequencer for the surface slot table
// Accepts a request, runs the match step, then decides the write-back
// and report from the match and slot-range status.
// ----------------------------------------------------------------------------
module kssl_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire kssl_pkg::dp_status_t status,
  output logic                      busy,
  output kssl_pkg::ctrl_cmd_t       cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MATCH = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    case (state)
      S_IDLE:  state_next = start ? S_MATCH : S_IDLE;
      S_MATCH: state_next = S_EXEC;
      S_EXEC:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.sel   = kssl_pkg::SEL_HIT;
    cmd.load  = start && !busy;
    cmd.match = (state == S_MATCH);
    if (state == S_EXEC) begin
      cmd.exec = 1'b1;
      case (status.kind)
        kssl_pkg::KIND_ALLOC: begin
          if (status.hit) begin
            cmd.ok = 1'b1; cmd.rec_en = 1'b1; cmd.wr = 1'b1;
          end else if (status.room) begin
            cmd.ok = 1'b1; cmd.rec_en = 1'b1; cmd.wr = 1'b1;
            cmd.claim = 1'b1;
            cmd.sel   = kssl_pkg::SEL_FREE;
          end
        end
        kssl_pkg::KIND_FREE, kssl_pkg::KIND_SETB, kssl_pkg::KIND_SETV: begin
          if (status.hit) begin
            cmd.ok = 1'b1; cmd.rec_en = 1'b1; cmd.wr = 1'b1;
          end
        end
        kssl_pkg::KIND_FIND: begin
          if (status.hit) begin
            cmd.ok = 1'b1; cmd.rec_en = 1'b1;
          end
        end
        kssl_pkg::KIND_READ: begin
          cmd.sel = kssl_pkg::SEL_PICK;
          if (status.pick_ok) begin
            cmd.ok = 1'b1; cmd.rec_en = 1'b1;
          end
        end
        default: begin
          cmd.ok = 1'b0;
        end
      endcase
    end
  end

  a_accept_to_match: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> state == S_MATCH)
    else $error("accepted request did not enter match");

  a_match_to_exec: assert property (@(posedge clk) disable iff (rst)
    state == S_MATCH |=> state == S_EXEC)
    else $error("match step not followed by execute");

  a_write_implies_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.wr |-> cmd.exec && cmd.ok && cmd.rec_en)
    else $error("write-back on a failed request");

endmodule
`default_nettype wire

@@ src/keyed_surface_slot_table.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_surface_slot_table - table of surface slots keyed by a 32-bit id
// Alloc/update, free, find, read by slot, set bounds and set visibility.
//
//   port          dir  role
//   start/item    in   request; taken when start is high and busy is low
//   busy          out  high while a request is being worked on
//   done/result   out  one result per request, valid for one cycle on done
//
// After the accepting edge a request runs through the busy states match,
// which checks the key against all slots in parallel, and execute, which
// reads the chosen record and, for a change, modifies and writes it back.
// The result shows on the cycle after execute, when a new request can be taken.
// Synchronous reset clears every slot and the live count at once.
// Results cannot be stalled.
// ----------------------------------------------------------------------------
module keyed_surface_slot_table (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire kssl_pkg::item_t   item,
  output logic                   busy,
  output logic                   done,
  output kssl_pkg::result_t      result
);

  kssl_pkg::ctrl_cmd_t  cmd;
  kssl_pkg::dp_status_t status;

  kssl_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  kssl_dpath u_dpath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .status (status),
    .done   (done),
    .result (result)
  );

endmodule
`default_nettype wire
